@@ hdl/sdf_pkg.sv @@
package sdf_pkg;

    // width of the value port, fixed by the interface
    localparam int unsigned VALUE_W = 64;
    // width of a text character
    localparam int unsigned CHAR_W = 6;
    // magnitude bits folded into the bcd register per cycle
    localparam int unsigned STEP_BITS = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef struct packed {
        logic load;
        logic step;
        logic scan;
        logic emit_sign;
        logic emit_digit;
    } sdf_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic out_free;
        logic last_digit;
    } sdf_stat_t;

endpackage

@@ hdl/sdf_datapath.sv @@
module sdf_datapath #(
    parameter int VALUE_BITS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [sdf_pkg::VALUE_W-1:0]    s_value,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [sdf_pkg::CHAR_W-1:0]     m_text_char,
    output logic                           m_last,
    input  sdf_pkg::sdf_cmd_t              cmd,
    output sdf_pkg::sdf_stat_t             stat
);
    import sdf_pkg::*;

    localparam int NDIGITS  = (VALUE_BITS * 31) / 100 + 1;
    localparam int BCD_W    = NDIGITS * 4;
    localparam int IDX_W    = $clog2(NDIGITS);
    localparam int NSTEPS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS = NSTEPS * STEP_BITS;
    localparam int CNT_W    = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

    logic [VALUE_BITS-1:0] val_c;
    logic [VALUE_BITS-1:0] mag_c;
    logic [PAD_BITS-1:0]   shift_reg, shift_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  neg_reg;
    logic [IDX_W-1:0]      idx_reg, idx_scan;
    logic                  m_valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;
    logic [3:0]            cur_digit;

    assign val_c = s_value[VALUE_BITS-1:0];
    assign mag_c = val_c[VALUE_BITS-1] ? (~val_c + VALUE_BITS'(1)) : val_c;

    // double dabble, STEP_BITS shifts per cycle
    always_comb begin
        logic [BCD_W-1:0]    b;
        logic [PAD_BITS-1:0] s;
        b = bcd_reg;
        s = shift_reg;
        for (int i = 0; i < STEP_BITS; i++) begin
            for (int d = 0; d < NDIGITS; d++) begin
                if (b[d*4 +: 4] >= 4'd5) begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], s[PAD_BITS-1]};
            s = {s[PAD_BITS-2:0], 1'b0};
        end
        bcd_next   = b;
        shift_next = s;
    end

    // highest nonzero digit, zero if all digits are zero
    always_comb begin
        idx_scan = '0;
        for (int d = 0; d < NDIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] != 4'd0) begin
                idx_scan = IDX_W'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            shift_reg <= PAD_BITS'(mag_c);
            bcd_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= val_c[VALUE_BITS-1];
        end else if (cmd.step) begin
            shift_reg <= shift_next;
            bcd_reg   <= bcd_next;
            cnt_reg   <= cnt_reg + CNT_W'(1);
        end
        if (cmd.scan) begin
            idx_reg <= idx_scan;
        end else if (cmd.emit_digit) begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
        if (cmd.emit_sign) begin
            char_reg <= ASCII_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg <= ASCII_ZERO + {2'b00, cur_digit};
            last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_text_char = char_reg;
    assign m_last      = last_reg;

    assign stat.conv_done  = (cnt_reg == CNT_W'(NSTEPS - 1));
    assign stat.neg        = neg_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.last_digit = (idx_reg == '0);

endmodule

@@ hdl/sdf_controller.sv @@
module sdf_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output sdf_pkg::sdf_cmd_t   cmd,
    input  sdf_pkg::sdf_stat_t  stat
);
    import sdf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (stat.conv_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = stat.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.last_digit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.step, cmd.scan, cmd.emit_sign, cmd.emit_digit}))
        else $error("more than one datapath command");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new transaction taken during conversion");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> stat.out_free)
        else $error("output register overwritten");

    a_sign_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sign |-> stat.neg)
        else $error("minus sign for non-negative value");
`endif

endmodule

@@ hdl/signed_decimal_formatter_core.sv @@
// after an input transaction the bcd conversion folds 8 magnitude bits per cycle into the
// digit register, then a scan finds the highest digit and the characters follow:
// one character per cycle while m_ready is high; up to 20 characters at 64 bits
// a new value is accepted only after the last character of the previous one is emitted
// reset: synchronous active-low aresetn clears the controller and output valid
module signed_decimal_formatter_core #(
    parameter int VALUE_BITS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sdf_pkg::VALUE_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sdf_pkg::CHAR_W-1:0]  m_text_char,
    output logic                        m_last
);
    import sdf_pkg::*;

    sdf_cmd_t  cmd;
    sdf_stat_t stat;

    sdf_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sdf_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_text_char (m_text_char),
        .m_last      (m_last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

// expected text of each accepted value, compared character by character
class decimal_text_board;
    localparam int MAX_DIGITS = 19;

    typedef struct packed {
        logic [sdf_pkg::CHAR_W-1:0] code;
        logic                       last;
    } text_char_t;

    text_char_t expected_chars[$];
    int value_bits;
    int errors;
    int checked;
    int negatives;

    function new(int bits);
        value_bits = bits;
        errors = 0;
        checked = 0;
        negatives = 0;
    endfunction

    function void note_value(logic [63:0] value);
        logic [63:0] sign_bit;
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digits [0:MAX_DIGITS-1];
        int          nd;
        text_char_t  tc;

        sign_bit = 64'd1 << (value_bits - 1);
        mask = sign_bit | (sign_bit - 64'd1);
        v = value & mask;
        neg = (v & sign_bit) != 64'd0;
        // magnitude in unsigned arithmetic, so the most negative value stays exact
        mag = neg ? ((~v + 64'd1) & mask) : v;
        if (neg) negatives++;
        nd = 0;
        do begin
            digits[nd] = 4'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
        end while (mag != 64'd0 && nd < MAX_DIGITS);
        if (neg) begin
            tc.code = sdf_pkg::ASCII_MINUS;
            tc.last = 1'b0;
            expected_chars.push_back(tc);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            tc.code = sdf_pkg::ASCII_ZERO + 6'(digits[k]);
            tc.last = (k == 0);
            expected_chars.push_back(tc);
        end
    endfunction

    function void check_char(logic [sdf_pkg::CHAR_W-1:0] code, logic last);
        text_char_t want;
        checked++;
        if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected character: char %0d last %0b", code, last);
            return;
        end
        want = expected_chars.pop_front();
        if (code !== want.code || last !== want.last) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                    want.code, want.last, code, last);
        end
    endfunction
endclass

module testbench;
    localparam int VALUE_BITS   = 64;
    localparam int RANDOM_ITEMS = 187;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [sdf_pkg::VALUE_W-1:0]      s_value = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [sdf_pkg::CHAR_W-1:0]       m_text_char;
    logic                             m_last;

    decimal_text_board board = new(VALUE_BITS);

    int cycles = 0;
    int sent = 0;
    int ready_mode = 0;
    int mode_left = 0;

    signed_decimal_formatter_core #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_text_char(m_text_char),
        .m_last(m_last)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: check each character, stall in stretches of varying pressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_char(m_text_char, m_last);
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(10, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [63:0] pow10(int n);
        logic [63:0] p;
        p = 64'd1;
        repeat (n) p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [63:0] random_value();
        int          kind;
        int          nd;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mag;
        logic [63:0] raw;
        kind = $urandom_range(0, 9);
        raw = {$urandom, $urandom};
        if (kind < 4) return raw;
        if (kind < 8) begin
            // uniform over a chosen digit count
            nd = $urandom_range(1, 19);
            lo = (nd == 1) ? 64'd0 : pow10(nd - 1);
            hi = (nd == 19) ? 64'h7FFF_FFFF_FFFF_FFFF : pow10(nd) - 64'd1;
            mag = lo + raw % (hi - lo + 64'd1);
        end else begin
            // around a power of ten
            nd = $urandom_range(1, 18);
            mag = pow10(nd) + 64'($urandom_range(0, 2)) - 64'd1;
        end
        return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
    endfunction

    task automatic send_value(input logic [63:0] v);
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_value(v);
        sent++;
    endtask

    task automatic hold_off(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_chars.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [63:0] values[$];
        int          directed_count;
        int          burst_left;

        values = '{64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99,
                   64'd100, -64'sd100, 64'd12345, -64'sd67890,
                   64'd999_999_999_999_999_999, 64'd1_000_000_000_000_000_000,
                   -64'sd1_000_000_000_000_000_000, -64'sd1_000_000_000_000_000_001,
                   64'd1_000_000_000_000_007, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'h7FFF_FFFF_FFFF_FFFE};
        directed_count = values.size();
        repeat (RANDOM_ITEMS) values.push_back(random_value());

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = 0;
        foreach (values[i]) begin
            // let the block empty out after the directed part and midway through
            if (i == directed_count || i == directed_count + RANDOM_ITEMS / 2)
                wait_drained();
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 12));
                burst_left = $urandom_range(1, 12);
            end
            send_value(values[i]);
            burst_left--;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("formatted %0d values (%0d directed, %0d negative), %0d characters checked",
            sent, directed_count, board.negatives, board.checked);
        $display("mismatches or unexpected characters: %0d", board.errors);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/sdf_pkg.sv
hdl/sdf_datapath.sv
hdl/sdf_controller.sv
hdl/signed_decimal_formatter_core.sv
test/testbench.sv
